>>> hw/rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  // Page table geometry.
  localparam int NUM_PAGES   = 4096;
  localparam int PAGE_W      = 12;
  localparam int LINK_W      = 13;
  localparam int MAX_ORDER   = 10;
  localparam int ORDER_SLOTS = MAX_ORDER + 1;
  localparam int ORD_W       = 4;
  localparam int BCNT_W      = 13;
  localparam int TOTAL_W     = 13;
  localparam int REF_W       = 8;

  // A link or list end equal to NUM_PAGES means "no page".
  localparam logic [LINK_W-1:0] NIL      = LINK_W'(NUM_PAGES);
  localparam logic [ORD_W-1:0]  ORD_NONE = 4'hF;

  // Action codes.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_ADD   = 2'd2;

  // Status codes.
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOFREE  = 2'd1;
  localparam logic [1:0] STS_BADORD  = 2'd2;
  localparam logic [1:0] STS_IGNORED = 2'd3;

  // Per-page attributes kept in one memory word.
  typedef struct packed {
    logic [ORD_W-1:0] ord;
    logic             free;
    logic             inv;
    logic [REF_W-1:0] cnt;
  } attr_t;

  localparam attr_t ATTR_RESET = '{ord: ORD_NONE, free: 1'b0, inv: 1'b1, cnt: '0};

  // Memory access requests from the sequencer to the page store.
  typedef struct packed {
    logic              attr_re;
    logic [PAGE_W-1:0] attr_raddr;
    logic              attr_we;
    logic [PAGE_W-1:0] attr_waddr;
    attr_t             attr_wdata;
    logic              link_re;
    logic [PAGE_W-1:0] link_raddr;
    logic              next_we;
    logic [PAGE_W-1:0] next_waddr;
    logic [LINK_W-1:0] next_wdata;
    logic              prev_we;
    logic [PAGE_W-1:0] prev_waddr;
    logic [LINK_W-1:0] prev_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic [ORD_W-1:0]  order;
    logic [1:0]        action;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] free_total;
    logic [PAGE_W-1:0]  block_page;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FREE_CHK,
    S_ADD_CHK,
    S_SPLIT_GO,
    S_SPLIT_WR,
    S_SPLIT_B,
    S_SPLIT_NEXT,
    S_ALLOC_TAKE,
    S_ALLOC_WR,
    S_UNLINK,
    S_PUSH,
    S_PUSH_LINK,
    S_REL_TEST,
    S_REL_CHK,
    S_REL_MERGE,
    S_REL_END,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bpa_store.sv
`default_nettype none

module bpa_store
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mem_req_t          req,
  output attr_t                  attr_rdata,
  output logic [LINK_W-1:0]      next_rdata,
  output logic [LINK_W-1:0]      prev_rdata,
  output logic                   clearing
);

  attr_t             attr_mem [NUM_PAGES];
  logic [LINK_W-1:0] next_mem [NUM_PAGES];
  logic [LINK_W-1:0] prev_mem [NUM_PAGES];
  logic [PAGE_W-1:0] clr_addr;

  // Clearing pass over the attribute memory after reset, one page a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Attribute memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      attr_mem[clr_addr] <= ATTR_RESET;
    end else if (req.attr_we) begin
      attr_mem[req.attr_waddr] <= req.attr_wdata;
    end
    if (req.attr_re) begin
      attr_rdata <= attr_mem[req.attr_raddr];
    end
  end

  // Forward links of the free lists.
  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_waddr] <= req.next_wdata;
    end
    if (req.link_re) begin
      next_rdata <= next_mem[req.link_raddr];
    end
  end

  // Backward links of the free lists.
  always_ff @(posedge clk) begin
    if (req.prev_we) begin
      prev_mem[req.prev_waddr] <= req.prev_wdata;
    end
    if (req.link_re) begin
      prev_rdata <= prev_mem[req.link_raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              busy,
  input  wire logic [PAGE_W-1:0] kfirst,
  input  wire logic [PAGE_W-1:0] klast,
  input  wire logic              in_valid,
  input  wire item_t             in_item,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_res,
  output mem_req_t               req,
  input  wire attr_t             attr_rdata,
  input  wire logic [LINK_W-1:0] next_rdata,
  input  wire logic [LINK_W-1:0] prev_rdata
);

  state_t st, st_next, uret, uret_next, pret, pret_next;
  logic [LINK_W-1:0]  head [ORDER_SLOTS];
  logic [LINK_W-1:0]  head_next [ORDER_SLOTS];
  logic [LINK_W-1:0]  tail [ORDER_SLOTS];
  logic [LINK_W-1:0]  tail_next [ORDER_SLOTS];
  logic [BCNT_W-1:0]  bcnt [ORDER_SLOTS];
  logic [BCNT_W-1:0]  bcnt_next [ORDER_SLOTS];
  logic [TOTAL_W-1:0] total, total_next;
  logic [ORD_W-1:0]   req_order, req_order_next;
  logic [ORD_W-1:0]   k_r, k_next;
  logic [ORD_W-1:0]   u_o, u_o_next;
  logic [ORD_W-1:0]   o_cur, o_cur_next;
  logic [ORD_W-1:0]   first_o, first_next;
  logic [ORD_W-1:0]   push_o, push_o_next;
  logic [PAGE_W-1:0]  push_p, push_p_next;
  logic [PAGE_W-1:0]  push_h, push_h_next;
  logic [PAGE_W-1:0]  page_r, page_next;
  logic [PAGE_W-1:0]  bud, bud_next;
  attr_t              cur, cur_next;
  attr_t              bud_attr, bud_attr_next;
  logic [1:0]         status_r, status_next;
  logic [PAGE_W-1:0]  block_r, block_next;
  logic               out_valid_next;
  result_t            out_res_next;
  logic               found;
  logic [ORD_W-1:0]   fk;

  // Smallest order at or above the request with a free block.
  always_comb begin
    found = 1'b0;
    fk = '0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (ORD_W'(i) >= in_item.order && bcnt[i] != '0) begin
        found = 1'b1;
        fk = ORD_W'(i);
      end
    end
  end

  assign in_ready = (st == S_IDLE) && !busy;

  // Next state, memory requests and list updates.
  always_comb begin
    attr_t             w;
    logic [PAGE_W-1:0] bit_m;
    logic [PAGE_W-1:0] b;
    logic [LINK_W-1:0] h;
    st_next = st;
    uret_next = uret;
    pret_next = pret;
    head_next = head;
    tail_next = tail;
    bcnt_next = bcnt;
    total_next = total;
    req_order_next = req_order;
    k_next = k_r;
    u_o_next = u_o;
    o_cur_next = o_cur;
    first_next = first_o;
    push_o_next = push_o;
    push_p_next = push_p;
    push_h_next = push_h;
    page_next = page_r;
    bud_next = bud;
    cur_next = cur;
    bud_attr_next = bud_attr;
    status_next = status_r;
    block_next = block_r;
    out_valid_next = out_valid;
    out_res_next = out_res;
    req = '0;
    w = attr_rdata;
    bit_m = PAGE_W'(1) << o_cur;
    b = page_r ^ (PAGE_W'(1) << (k_r - 1'b1));
    h = head[push_o];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (st)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_order_next = in_item.order;
          page_next = in_item.page_number;
          status_next = STS_IGNORED;
          block_next = '0;
          st_next = S_DONE;
          case (in_item.action)
            ACT_ALLOC: begin
              if (in_item.order > ORD_W'(MAX_ORDER)) begin
                status_next = STS_BADORD;
              end else if (!found) begin
                status_next = STS_NOFREE;
              end else begin
                k_next = fk;
                st_next = (fk > in_item.order) ? S_SPLIT_GO : S_ALLOC_TAKE;
              end
            end
            ACT_FREE: begin
              req.attr_re = 1'b1;
              req.attr_raddr = in_item.page_number;
              st_next = S_FREE_CHK;
            end
            ACT_ADD: begin
              req.attr_re = 1'b1;
              req.attr_raddr = in_item.page_number;
              st_next = S_ADD_CHK;
            end
            default: begin
              st_next = S_DONE;
            end
          endcase
        end
      end

      // Split the oldest block of order k into two halves.
      S_SPLIT_GO: begin
        page_next = tail[k_r][PAGE_W-1:0];
        u_o_next = k_r;
        req.link_re = 1'b1;
        req.link_raddr = tail[k_r][PAGE_W-1:0];
        uret_next = S_SPLIT_WR;
        st_next = S_UNLINK;
      end
      S_SPLIT_WR: begin
        req.attr_we = 1'b1;
        req.attr_waddr = page_r;
        req.attr_wdata = '{ord: k_r - 1'b1, free: 1'b1, inv: 1'b0, cnt: '0};
        push_o_next = k_r - 1'b1;
        push_p_next = page_r;
        pret_next = S_SPLIT_B;
        st_next = S_PUSH;
      end
      S_SPLIT_B: begin
        req.attr_we = 1'b1;
        req.attr_waddr = b;
        req.attr_wdata = '{ord: k_r - 1'b1, free: 1'b1, inv: 1'b0, cnt: '0};
        push_o_next = k_r - 1'b1;
        push_p_next = b;
        pret_next = S_SPLIT_NEXT;
        st_next = S_PUSH;
      end
      S_SPLIT_NEXT: begin
        k_next = k_r - 1'b1;
        st_next = ((k_r - 1'b1) > req_order) ? S_SPLIT_GO : S_ALLOC_TAKE;
      end

      // Take the oldest block of the requested order.
      S_ALLOC_TAKE: begin
        if (bcnt[req_order] == '0 || tail[req_order][PAGE_W]) begin
          status_next = STS_NOFREE;
          st_next = S_DONE;
        end else begin
          page_next = tail[req_order][PAGE_W-1:0];
          u_o_next = req_order;
          req.link_re = 1'b1;
          req.link_raddr = tail[req_order][PAGE_W-1:0];
          uret_next = S_ALLOC_WR;
          st_next = S_UNLINK;
        end
      end
      S_ALLOC_WR: begin
        req.attr_we = 1'b1;
        req.attr_waddr = page_r;
        req.attr_wdata = '{ord: req_order, free: 1'b0, inv: 1'b0, cnt: REF_W'(1)};
        total_next = total - (TOTAL_W'(1) << req_order);
        status_next = STS_OK;
        block_next = page_r;
        st_next = S_DONE;
      end

      // Remove a page from list u_o using the links read last cycle.
      S_UNLINK: begin
        if (!prev_rdata[PAGE_W]) begin
          req.next_we = 1'b1;
          req.next_waddr = prev_rdata[PAGE_W-1:0];
          req.next_wdata = next_rdata;
        end else begin
          head_next[u_o] = next_rdata;
        end
        if (!next_rdata[PAGE_W]) begin
          req.prev_we = 1'b1;
          req.prev_waddr = next_rdata[PAGE_W-1:0];
          req.prev_wdata = prev_rdata;
        end else begin
          tail_next[u_o] = prev_rdata;
        end
        if (bcnt[u_o] != '0) begin
          bcnt_next[u_o] = bcnt[u_o] - 1'b1;
        end
        st_next = uret;
      end

      // Insert push_p at the head of list push_o.
      S_PUSH: begin
        req.next_we = 1'b1;
        req.next_waddr = push_p;
        req.next_wdata = h;
        req.prev_we = 1'b1;
        req.prev_waddr = push_p;
        req.prev_wdata = NIL;
        head_next[push_o] = {1'b0, push_p};
        bcnt_next[push_o] = bcnt[push_o] + 1'b1;
        if (h[PAGE_W]) begin
          tail_next[push_o] = {1'b0, push_p};
          st_next = pret;
        end else begin
          push_h_next = h[PAGE_W-1:0];
          st_next = S_PUSH_LINK;
        end
      end
      S_PUSH_LINK: begin
        req.prev_we = 1'b1;
        req.prev_waddr = push_h;
        req.prev_wdata = {1'b0, push_p};
        st_next = pret;
      end

      // Free: drop the count and release the block when it reaches zero.
      S_FREE_CHK: begin
        st_next = S_DONE;
        if (attr_rdata.ord != ORD_NONE && !attr_rdata.inv && attr_rdata.cnt != '0) begin
          w.cnt = attr_rdata.cnt - 1'b1;
          req.attr_we = 1'b1;
          req.attr_waddr = page_r;
          req.attr_wdata = w;
          status_next = STS_OK;
          if (w.cnt == '0) begin
            cur_next = w;
            o_cur_next = attr_rdata.ord;
            first_next = attr_rdata.ord;
            st_next = S_REL_TEST;
          end
        end
      end

      // Add: bring a page in unless it is known or in the kernel range.
      S_ADD_CHK: begin
        st_next = S_DONE;
        if (attr_rdata.inv && !(page_r >= kfirst && page_r <= klast)) begin
          w.inv = 1'b0;
          req.attr_we = 1'b1;
          req.attr_waddr = page_r;
          req.attr_wdata = w;
          cur_next = w;
          o_cur_next = '0;
          first_next = '0;
          status_next = STS_OK;
          st_next = S_REL_TEST;
        end
      end

      // Merge loop: look at the buddy of the current order.
      S_REL_TEST: begin
        if (o_cur < ORD_W'(MAX_ORDER)) begin
          bud_next = page_r ^ bit_m;
          req.attr_re = 1'b1;
          req.attr_raddr = page_r ^ bit_m;
          st_next = S_REL_CHK;
        end else begin
          st_next = S_REL_END;
        end
      end
      S_REL_CHK: begin
        if (attr_rdata.ord == o_cur && !attr_rdata.inv && attr_rdata.free) begin
          bud_attr_next = attr_rdata;
          req.link_re = 1'b1;
          req.link_raddr = bud;
          u_o_next = o_cur;
          uret_next = S_REL_MERGE;
          st_next = S_UNLINK;
        end else begin
          st_next = S_REL_END;
        end
      end
      S_REL_MERGE: begin
        req.attr_we = 1'b1;
        if ((bud & bit_m) != '0) begin
          req.attr_waddr = bud;
          req.attr_wdata = '{ord: ORD_NONE, free: 1'b0, inv: bud_attr.inv, cnt: bud_attr.cnt};
        end else begin
          req.attr_waddr = page_r;
          req.attr_wdata = '{ord: ORD_NONE, free: cur.free, inv: cur.inv, cnt: cur.cnt};
          cur_next = bud_attr;
          cur_next.free = 1'b0;
          page_next = bud;
        end
        o_cur_next = o_cur + 1'b1;
        st_next = S_REL_TEST;
      end
      S_REL_END: begin
        req.attr_we = 1'b1;
        req.attr_waddr = page_r;
        req.attr_wdata = '{ord: o_cur, free: 1'b1, inv: cur.inv, cnt: cur.cnt};
        total_next = total + (TOTAL_W'(1) << first_o);
        push_o_next = o_cur;
        push_p_next = page_r;
        pret_next = S_DONE;
        st_next = S_PUSH;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next = '{free_total: total, block_page: block_r, status: status_r};
          st_next = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      total <= '0;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
        bcnt[i] <= '0;
      end
    end else begin
      st <= st_next;
      out_valid <= out_valid_next;
      total <= total_next;
      head <= head_next;
      tail <= tail_next;
      bcnt <= bcnt_next;
    end
  end

  // Working registers of the current action.
  always_ff @(posedge clk) begin
    uret <= uret_next;
    pret <= pret_next;
    req_order <= req_order_next;
    k_r <= k_next;
    u_o <= u_o_next;
    o_cur <= o_cur_next;
    first_o <= first_next;
    push_o <= push_o_next;
    push_p <= push_p_next;
    push_h <= push_h_next;
    page_r <= page_next;
    bud <= bud_next;
    cur <= cur_next;
    bud_attr <= bud_attr_next;
    status_r <= status_next;
    block_r <= block_next;
    out_res <= out_res_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/buddy_page_allocator.sv
// A rejected allocate goes straight to the result; an allocate splits once per order
// above the request, then takes a block; a free or add reads the page attributes, and
// a release merges buddies (up to 10 levels). Throughput: one action at a time; the
// next beat is taken the cycle after the result is registered, a waiting result only
// holds the next one. Reset: synchronous, active high. After reset a clearing pass
// rewrites the attribute memory of all 4096 pages; s_axis_tready stays low until it ends.
`default_nettype none

module buddy_page_allocator
  import bpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // action[1:0], order[5:2], page_number[17:6]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // status[1:0], block_page[13:2], free_total[26:14]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic [PAGE_W-1:0] kfirst;
  logic [PAGE_W-1:0] klast;
  mem_req_t          req;
  attr_t             attr_rdata;
  logic [LINK_W-1:0] next_rdata;
  logic [LINK_W-1:0] prev_rdata;
  logic              clearing;
  item_t             item;
  result_t           res;

  // Kernel range registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kfirst <= '0;
      klast <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 1'b0) begin
        kfirst <= cfg_data;
      end else begin
        klast <= cfg_data;
      end
    end
  end

  // Beat packing.
  assign item = s_axis_tdata[$bits(item_t)-1:0];
  assign m_axis_tdata = {{(32 - $bits(result_t)){1'b0}}, res};

  bpa_store u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .attr_rdata (attr_rdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .clearing   (clearing)
  );

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .busy       (clearing),
    .kfirst     (kfirst),
    .klast      (klast),
    .in_valid   (s_axis_tvalid),
    .in_item    (item),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res),
    .req        (req),
    .attr_rdata (attr_rdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata)
  );

  // No beat is taken while the attribute memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // Reset always starts a clearing pass.
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> clearing)
    else $error("clearing pass not started by reset");

  // The free page total never exceeds the page table.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.free_total <= TOTAL_W'(NUM_PAGES)))
    else $error("free page total out of range");

endmodule

`default_nettype wire
